### sv/stbq_pkg.sv
// ----------------------------------------------------------------------------
// stbq_pkg
// Shared types and codes for the segmenting transmit buffer queue.
// ----------------------------------------------------------------------------
package stbq_pkg;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_DATA  = 2'd1,
        OP_TICK  = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ADMIT_OK       = 2'd0,
        ADMIT_NO_ROOM  = 2'd1,
        ADMIT_ARRIVING = 2'd2
    } admit_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LEN,
        ST_EMIT
    } drain_state_t;

    localparam logic KIND_ADMIT = 1'b0;
    localparam logic KIND_BYTE  = 1'b1;

endpackage

### sv/segmenting_tx_buffer_queue.sv
// ----------------------------------------------------------------------------
// segmenting_tx_buffer_queue
// Transmit queue of NUM_BUFFERS slots of CHUNK_LEN bytes, drained chunk-wise.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Start, data and tick
// requests that do not begin a drain leave busy low; an admission answer comes
// out on result_strobe in the following cycle. A tick that begins a drain
// holds busy while the slot length RAM is read, then while the chunk bytes
// are read from the chunk RAM read port; an empty slot ends the drain after
// the length read. Bytes leave one per cycle from an output register behind
// the RAM read, and must be taken as they come since the receiver cannot stall.
// Slot storage needs no clearing after reset.
module segmenting_tx_buffer_queue
    import stbq_pkg::*;
#(
    parameter int NUM_BUFFERS = 8,
    parameter int CHUNK_LEN   = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] opcode,
    input  logic [7:0] msg_length,
    input  logic [7:0] data_byte,
    input  logic       line_idle,
    output logic       result_strobe,
    output logic       result_kind,
    output logic [1:0] admit_status,
    output logic [7:0] tx_byte,
    output logic       last_of_chunk,
    output logic       chunk_empty
);

    localparam int SW    = $clog2(NUM_BUFFERS);
    localparam int PW    = (CHUNK_LEN > 1) ? $clog2(CHUNK_LEN) : 1;
    localparam int LW    = $clog2(CHUNK_LEN + 1);
    localparam int CW    = $clog2(NUM_BUFFERS + 1);
    localparam int AW    = SW + PW;
    localparam int BDEPTH = NUM_BUFFERS << PW;
    localparam int PRODW = CW + LW;
    localparam int CMPW  = (PRODW > 8) ? PRODW : 8;

    localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_BUFFERS - 1);
    localparam logic [CW-1:0] NUM_B     = CW'(NUM_BUFFERS);
    localparam logic [LW-1:0] CHUNK_L   = LW'(CHUNK_LEN);

    drain_state_t  state_reg, state_next;
    logic [SW-1:0] write_slot_reg, write_slot_next;
    logic [SW-1:0] read_slot_reg, read_slot_next;
    logic [CW-1:0] free_slots_reg, free_slots_next;
    logic [CW-1:0] ready_slots_reg, ready_slots_next;
    logic          sending_reg, sending_next;
    logic [7:0]    pending_reg, pending_next;
    logic [LW-1:0] fill_reg, fill_next;
    logic [LW-1:0] n_reg, n_next;
    logic [LW-1:0] emit_cnt_reg, emit_cnt_next;

    logic          strobe_reg, strobe_next;
    logic          kind_reg, kind_next;
    logic [1:0]    status_reg, status_next;
    logic [7:0]    txb_reg, txb_next;
    logic          last_reg, last_next;
    logic          empty_reg, empty_next;

    logic          accept;
    logic          do_close;
    logic [LW-1:0] close_len;
    logic [LW-1:0] fill_inc;
    logic [LW-1:0] emit_inc;
    logic [CMPW-1:0] room;

    logic          byte_we;
    logic [AW-1:0] byte_waddr;
    logic [AW-1:0] byte_raddr;
    logic [7:0]    byte_rdata;
    logic          len_we;
    logic [SW-1:0] len_waddr;
    logic [LW-1:0] len_wdata;
    logic [LW-1:0] len_rdata;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign room   = CMPW'(free_slots_reg) * CMPW'(CHUNK_LEN);
    assign fill_inc = fill_reg + LW'(1);
    assign emit_inc = emit_cnt_reg + LW'(1);

    // The writer only touches free slots and the drain only reads ready ones,
    // so reads and writes never meet on one entry.
    stbq_ram #(.WIDTH(8), .DEPTH(BDEPTH)) u_chunk_ram (
        .clk   (clk),
        .we    (byte_we),
        .waddr (byte_waddr),
        .wdata (data_byte),
        .raddr (byte_raddr),
        .rdata (byte_rdata)
    );

    stbq_ram #(.WIDTH(LW), .DEPTH(NUM_BUFFERS)) u_len_ram (
        .clk   (clk),
        .we    (len_we),
        .waddr (len_waddr),
        .wdata (len_wdata),
        .raddr (read_slot_reg),
        .rdata (len_rdata)
    );

    always_comb
    begin
        state_next       = state_reg;
        write_slot_next  = write_slot_reg;
        read_slot_next   = read_slot_reg;
        free_slots_next  = free_slots_reg;
        ready_slots_next = ready_slots_reg;
        sending_next     = sending_reg;
        pending_next     = pending_reg;
        fill_next        = fill_reg;
        n_next           = n_reg;
        emit_cnt_next    = emit_cnt_reg;
        strobe_next      = 1'b0;
        kind_next        = kind_reg;
        status_next      = status_reg;
        txb_next         = txb_reg;
        last_next        = last_reg;
        empty_next       = empty_reg;
        do_close         = 1'b0;
        close_len        = fill_reg;
        byte_we          = 1'b0;
        byte_waddr       = {write_slot_reg, fill_reg[PW-1:0]};
        byte_raddr       = {read_slot_reg, PW'(0)};
        len_we           = 1'b0;
        len_waddr        = write_slot_reg;
        len_wdata        = fill_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (opcode)
                        OP_START:
                        begin
                            strobe_next = 1'b1;
                            kind_next   = KIND_ADMIT;
                            txb_next    = 8'd0;
                            last_next   = 1'b0;
                            empty_next  = 1'b0;
                            if (pending_reg != 8'd0)
                            begin
                                status_next = ADMIT_ARRIVING;
                            end
                            else if (free_slots_reg == '0 ||
                                     CMPW'(msg_length) > room)
                            begin
                                status_next = ADMIT_NO_ROOM;
                            end
                            else
                            begin
                                status_next = ADMIT_OK;
                                if (msg_length == 8'd0)
                                begin
                                    do_close  = 1'b1;
                                    close_len = '0;
                                end
                                else
                                begin
                                    fill_next    = '0;
                                    pending_next = msg_length;
                                end
                            end
                        end
                        OP_DATA:
                        begin
                            if (pending_reg != 8'd0)
                            begin
                                byte_we      = 1'b1;
                                pending_next = pending_reg - 8'd1;
                                fill_next    = fill_inc;
                                if (fill_inc == CHUNK_L || pending_reg == 8'd1)
                                begin
                                    do_close  = 1'b1;
                                    close_len = fill_inc;
                                end
                            end
                        end
                        OP_TICK:
                        begin
                            if (!sending_reg)
                            begin
                                if (ready_slots_reg != '0)
                                begin
                                    ready_slots_next = ready_slots_reg - CW'(1);
                                    sending_next     = 1'b1;
                                    state_next       = ST_LEN;
                                end
                            end
                            else if (line_idle)
                            begin
                                if (free_slots_reg < NUM_B)
                                begin
                                    free_slots_next = free_slots_reg + CW'(1);
                                end
                                read_slot_next = (read_slot_reg == LAST_SLOT) ?
                                                 '0 : read_slot_reg + SW'(1);
                                sending_next   = 1'b0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_LEN:
            begin
                if (len_rdata == '0)
                begin
                    strobe_next = 1'b1;
                    kind_next   = KIND_BYTE;
                    status_next = ADMIT_OK;
                    txb_next    = 8'd0;
                    last_next   = 1'b1;
                    empty_next  = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    n_next        = len_rdata;
                    emit_cnt_next = '0;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                strobe_next   = 1'b1;
                kind_next     = KIND_BYTE;
                status_next   = ADMIT_OK;
                txb_next      = byte_rdata;
                last_next     = (emit_inc == n_reg);
                empty_next    = 1'b0;
                byte_raddr    = {read_slot_reg, emit_inc[PW-1:0]};
                emit_cnt_next = emit_inc;
                if (emit_inc == n_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (do_close)
        begin
            len_we    = 1'b1;
            len_wdata = close_len;
            write_slot_next = (write_slot_reg == LAST_SLOT) ?
                              '0 : write_slot_reg + SW'(1);
            if (free_slots_reg != '0)
            begin
                free_slots_next = free_slots_reg - CW'(1);
            end
            ready_slots_next = ready_slots_reg + CW'(1);
            fill_next        = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            write_slot_reg  <= '0;
            read_slot_reg   <= '0;
            free_slots_reg  <= NUM_B;
            ready_slots_reg <= '0;
            sending_reg     <= 1'b0;
            pending_reg     <= '0;
            fill_reg        <= '0;
            strobe_reg      <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            write_slot_reg  <= write_slot_next;
            read_slot_reg   <= read_slot_next;
            free_slots_reg  <= free_slots_next;
            ready_slots_reg <= ready_slots_next;
            sending_reg     <= sending_next;
            pending_reg     <= pending_next;
            fill_reg        <= fill_next;
            strobe_reg      <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        emit_cnt_reg <= emit_cnt_next;
        kind_reg     <= kind_next;
        status_reg   <= status_next;
        txb_reg      <= txb_next;
        last_reg     <= last_next;
        empty_reg    <= empty_next;
    end

    assign result_strobe = strobe_reg;
    assign result_kind   = kind_reg;
    assign admit_status  = status_reg;
    assign tx_byte       = txb_reg;
    assign last_of_chunk = last_reg;
    assign chunk_empty   = empty_reg;

    // An admission answer always follows an accepted start request.
    a_admit_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && result_kind == KIND_ADMIT |->
            $past(start && !busy && opcode == OP_START))
        else $error("admission answer without start request");

    // A chunk run is unbroken until its last byte.
    a_chunk_run: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && result_kind == KIND_BYTE && !last_of_chunk |=>
            result_strobe && result_kind == KIND_BYTE)
        else $error("chunk run broken before last byte");

    // The drain machine only runs while a slot is held for sending.
    a_drain_holds_slot: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> sending_reg)
        else $error("drain active without a held slot");

    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_slots_reg <= NUM_B && ready_slots_reg <= NUM_B)
        else $error("slot counter out of range");

endmodule

### sv/stbq_ram.sv
// ----------------------------------------------------------------------------
// stbq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module stbq_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
